[src/sphere_phong_shading_unit_macros.svh]
// Assertion macros used by the checker of the shading unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SPHERE_PHONG_SHADING_UNIT_MACROS_SVH
`define SPHERE_PHONG_SHADING_UNIT_MACROS_SVH

// Checked at every rising edge outside reset.
`define SPSH_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define SPSH_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/spsh_pkg.sv]
package spsh_pkg;

  // Working width of the vectors handed to the normaliser.
  localparam int VEC_W = 36;
  // Component magnitude after the range shift.
  localparam int MAG_W = 31;
  // Unit vectors are signed Q1.30 in 32 bits, clamped cosines unsigned Q1.30 in 31 bits.
  localparam int UNIT_W = 32;
  localparam int UNIT_BITS = 30;
  localparam int SIDE_W = 248;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;
  localparam int DIFF_W = 17;
  localparam int SPEC_W = 31;

  localparam logic [SPEC_W-1:0] UNIT_ONE = 31'h4000_0000;
  localparam logic [15:0] AMBIENT = 16'd26;
  localparam logic [15:0] OUT_MAX = 16'hFFFF;

  typedef logic signed [VEC_W-1:0] wide_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [DIFF_W-1:0] diff_t;
  typedef logic [SPEC_W-1:0] spec_t;

  typedef logic [2:0] reg_index_t;
  localparam reg_index_t REG_LIGHT_POS_X = 3'd0;
  localparam reg_index_t REG_LIGHT_POS_Y = 3'd1;
  localparam reg_index_t REG_LIGHT_POS_Z = 3'd2;
  localparam reg_index_t REG_LIGHT_RED = 3'd3;
  localparam reg_index_t REG_LIGHT_GREEN = 3'd4;
  localparam reg_index_t REG_LIGHT_BLUE = 3'd5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [31:0] hit_distance;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [23:0] sphere_color;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } out_item_t;

endpackage

[src/sphere_phong_shading_unit.sv]
// Phong shading of one ray-sphere hit under a single point light.
// Input channel: in_valid / in_stall with in_data (ray origin, direction of
// any length, hit distance, sphere centre, packed sphere colour).
// Output channel: out_valid / out_stall with out_data (red, green, blue in
// unsigned Q8.8, saturated). A transfer happens on a rising edge where valid
// is high and stall is low.
// The configuration port (cfg_write, cfg_index, cfg_data) sets the light
// position and colour; write it only while no hit is in flight.
// The path runs through three normalisers of 68 stages each in a row (a
// 32-stage square root and 31-stage dividers; the normal and light
// normalisers run side by side), ten arithmetic stages and one stage per
// step of the specular power.
// Throughput is one transfer per cycle unless stalled; every stage is a register level.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle, so nothing is lost or repeated.
// Synchronous reset clears all valid bits, sets the light position to zero
// and each light intensity to 1.0.
module sphere_phong_shading_unit #(
  parameter int SPECULAR_POWER = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  spsh_pkg::in_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output spsh_pkg::out_item_t    out_data,
  input  logic                   cfg_write,
  input  spsh_pkg::reg_index_t   cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int SW = spsh_pkg::SIDE_W;

  // Truncating division by 2^30 of a dot product sum.
  function automatic logic signed [34:0] q30_trunc(input logic signed [63:0] s);
    logic [63:0] m;
    logic [33:0] q;
    m = s[63] ? 64'(-s) : 64'(s);
    q = m[63:30];
    return s[63] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Cosine clamped to one, zero when not positive.
  function automatic spsh_pkg::spec_t clamp_cos(input logic signed [34:0] c);
    if (c > 35'sd1073741824) begin
      return spsh_pkg::UNIT_ONE;
    end else if (c > 35'sd0) begin
      return c[30:0];
    end
    return '0;
  endfunction

  // The whole pipeline moves unless a finished result is being held.
  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Light registers.
  logic signed [31:0] light_pos [3];
  logic [15:0] light_col [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        light_pos[i] <= '0;
        light_col[i] <= 16'd256;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        spsh_pkg::REG_LIGHT_POS_X: light_pos[0] <= cfg_data;
        spsh_pkg::REG_LIGHT_POS_Y: light_pos[1] <= cfg_data;
        spsh_pkg::REG_LIGHT_POS_Z: light_pos[2] <= cfg_data;
        spsh_pkg::REG_LIGHT_RED:   light_col[0] <= cfg_data[15:0];
        spsh_pkg::REG_LIGHT_GREEN: light_col[1] <= cfg_data[15:0];
        spsh_pkg::REG_LIGHT_BLUE:  light_col[2] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // View direction normaliser; the rest of the item rides alongside.
  spsh_pkg::wide_t u1_in [3];
  spsh_pkg::side_t u1_side_in, u1_side_out;
  spsh_pkg::unit_t u1_view [3];
  logic u1_valid;
  logic signed [31:0] u1_org [3];
  logic signed [31:0] u1_ctr [3];
  logic [31:0] u1_t;
  logic [23:0] u1_color;

  assign u1_in[0] = spsh_pkg::wide_t'(in_data.dir_x);
  assign u1_in[1] = spsh_pkg::wide_t'(in_data.dir_y);
  assign u1_in[2] = spsh_pkg::wide_t'(in_data.dir_z);
  assign u1_side_in = {in_data.origin_x, in_data.origin_y, in_data.origin_z,
                       in_data.hit_distance, in_data.center_x, in_data.center_y,
                       in_data.center_z, in_data.sphere_color};

  spsh_unitize u_view (
    .clk(clk), .rst(rst), .en(adv), .in_valid(in_valid),
    .vec_in(u1_in), .side_in(u1_side_in),
    .out_valid(u1_valid), .vec_out(u1_view), .side_out(u1_side_out)
  );

  assign {u1_org[0], u1_org[1], u1_org[2], u1_t, u1_ctr[0], u1_ctr[1], u1_ctr[2],
          u1_color} = u1_side_out;

  // Hit point P = O + t * V, then the normal and light vectors.
  logic [30:0] vmag [3];
  logic [62:0] tprod [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vmag[i] = 31'(u1_view[i][31] ? -u1_view[i] : u1_view[i]);
      tprod[i] = 63'(u1_t) * 63'(vmag[i]);
    end
  end

  logic h1_valid, h2_valid, h3_valid;
  logic [32:0] h1_term [3];
  logic h1_neg [3];
  logic signed [31:0] h1_org [3];
  logic signed [31:0] h1_ctr [3];
  logic signed [31:0] h2_ctr [3];
  spsh_pkg::unit_t h1_view [3], h2_view [3], h3_view [3];
  logic [23:0] h1_color, h2_color, h3_color;
  spsh_pkg::wide_t h2_hit [3];
  spsh_pkg::wide_t h3_nrm [3];
  spsh_pkg::wide_t h3_lvec [3];
  spsh_pkg::wide_t h1_tw [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h1_tw[i] = $signed({3'b000, h1_term[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_valid <= 1'b0;
      h2_valid <= 1'b0;
      h3_valid <= 1'b0;
    end else if (adv) begin
      h1_valid <= u1_valid;
      h2_valid <= h1_valid;
      h3_valid <= h2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        h1_term[i] <= tprod[i][62:30];
        h1_neg[i] <= u1_view[i][31];
        h1_org[i] <= u1_org[i];
        h1_ctr[i] <= u1_ctr[i];
        h1_view[i] <= u1_view[i];
        h2_hit[i] <= spsh_pkg::wide_t'(h1_org[i]) + (h1_neg[i] ? -h1_tw[i] : h1_tw[i]);
        h2_ctr[i] <= h1_ctr[i];
        h2_view[i] <= h1_view[i];
        h3_nrm[i] <= h2_hit[i] - spsh_pkg::wide_t'(h2_ctr[i]);
        h3_lvec[i] <= spsh_pkg::wide_t'(light_pos[i]) - h2_hit[i];
        h3_view[i] <= h2_view[i];
      end
      h1_color <= u1_color;
      h2_color <= h1_color;
      h3_color <= h2_color;
    end
  end

  // Normal and light normalisers run side by side with equal latency.
  spsh_pkg::side_t u2_side_in, u2_side_out, u3_side_in, u3_side_out;
  spsh_pkg::unit_t u2_nrm [3], u3_lit [3], u2_view [3];
  logic u2_valid, u3_valid;
  logic [23:0] u3_color;

  assign u2_side_in = {h3_view[0], h3_view[1], h3_view[2], {(SW - 96){1'b0}}};
  assign u3_side_in = {h3_color, {(SW - 24){1'b0}}};

  spsh_unitize u_normal (
    .clk(clk), .rst(rst), .en(adv), .in_valid(h3_valid),
    .vec_in(h3_nrm), .side_in(u2_side_in),
    .out_valid(u2_valid), .vec_out(u2_nrm), .side_out(u2_side_out)
  );

  spsh_unitize u_light (
    .clk(clk), .rst(rst), .en(adv), .in_valid(h3_valid),
    .vec_in(h3_lvec), .side_in(u3_side_in),
    .out_valid(u3_valid), .vec_out(u3_lit), .side_out(u3_side_out)
  );

  assign {u2_view[0], u2_view[1], u2_view[2]} = u2_side_out[SW-1 -: 96];
  assign u3_color = u3_side_out[SW-1 -: 24];

  // The light cosine, the reflection vector and the diffuse terms.
  logic d1_valid, d2_valid, d3_valid, d4_valid;
  logic signed [63:0] d1_prod [3];
  spsh_pkg::unit_t d1_lit [3], d1_nrm [3], d1_view [3];
  spsh_pkg::unit_t d2_lit [3], d2_nrm [3], d2_view [3];
  spsh_pkg::unit_t d3_lit [3], d3_view [3], d4_view [3];
  logic [23:0] d1_color, d2_color, d3_color;
  logic signed [34:0] d2_cos;
  logic [34:0] d3_k [3];
  logic d3_kneg [3];
  logic [46:0] d3_dp [3];
  logic d3_cpos, d4_cpos;
  spsh_pkg::wide_t d4_refl [3];
  spsh_pkg::diff_t d4_diff [3];

  logic [32:0] cmag;
  logic [30:0] nmag [3];
  logic [63:0] kprod [3];
  spsh_pkg::spec_t ct;
  spsh_pkg::wide_t kw [3];
  logic [54:0] dprod2 [3];
  logic [7:0] chan [3];

  always_comb begin
    cmag = 33'(d2_cos[34] ? -d2_cos : d2_cos);
    ct = clamp_cos(d2_cos);
    chan[0] = d3_color[23:16];
    chan[1] = d3_color[15:8];
    chan[2] = d3_color[7:0];
    for (int i = 0; i < 3; i++) begin
      nmag[i] = 31'(d2_nrm[i][31] ? -d2_nrm[i] : d2_nrm[i]);
      kprod[i] = 64'(cmag) * 64'(nmag[i]);
      kw[i] = $signed({1'b0, d3_k[i]});
      dprod2[i] = 55'(d3_dp[i]) * 55'(chan[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      d3_valid <= 1'b0;
      d4_valid <= 1'b0;
    end else if (adv) begin
      d1_valid <= u2_valid & u3_valid;
      d2_valid <= d1_valid;
      d3_valid <= d2_valid;
      d4_valid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_prod[i] <= 64'(u3_lit[i]) * 64'(u2_nrm[i]);
        d1_lit[i] <= u3_lit[i];
        d1_nrm[i] <= u2_nrm[i];
        d1_view[i] <= u2_view[i];
        d2_lit[i] <= d1_lit[i];
        d2_nrm[i] <= d1_nrm[i];
        d2_view[i] <= d1_view[i];
        d3_k[i] <= kprod[i][63:29];
        d3_kneg[i] <= d2_cos[34] ^ d2_nrm[i][31];
        d3_dp[i] <= 47'(ct) * 47'(light_col[i]);
        d3_lit[i] <= d2_lit[i];
        d3_view[i] <= d2_view[i];
        d4_refl[i] <= spsh_pkg::wide_t'(d3_lit[i]) - (d3_kneg[i] ? -kw[i] : kw[i]);
        d4_diff[i] <= dprod2[i][54:38];
        d4_view[i] <= d3_view[i];
      end
      d1_color <= u3_color;
      d2_color <= d1_color;
      d3_color <= d2_color;
      d2_cos <= q30_trunc(d1_prod[0] + d1_prod[1] + d1_prod[2]);
      d3_cpos <= d2_cos > 35'sd0;
      d4_cpos <= d3_cpos;
    end
  end

  // Reflection normaliser.
  spsh_pkg::side_t u4_side_in, u4_side_out;
  spsh_pkg::unit_t u4_refl [3], u4_view [3];
  spsh_pkg::diff_t u4_diff [3];
  logic u4_valid, u4_cpos;

  assign u4_side_in = {d4_view[0], d4_view[1], d4_view[2], d4_cpos,
                       d4_diff[0], d4_diff[1], d4_diff[2], {(SW - 148){1'b0}}};

  spsh_unitize u_reflect (
    .clk(clk), .rst(rst), .en(adv), .in_valid(d4_valid),
    .vec_in(d4_refl), .side_in(u4_side_in),
    .out_valid(u4_valid), .vec_out(u4_refl), .side_out(u4_side_out)
  );

  assign {u4_view[0], u4_view[1], u4_view[2], u4_cpos,
          u4_diff[0], u4_diff[1], u4_diff[2]} = u4_side_out[SW-1 -: 148];

  // The view cosine and the start of the specular chain.
  logic e1_valid, e2_valid;
  logic signed [63:0] e1_prod [3];
  logic e1_cpos;
  spsh_pkg::diff_t e1_diff [3], e2_diff [3];
  spsh_pkg::spec_t e2_p, e2_c;
  logic signed [34:0] cos_a;

  assign cos_a = q30_trunc(e1_prod[0] + e1_prod[1] + e1_prod[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      e2_valid <= 1'b0;
    end else if (adv) begin
      e1_valid <= u4_valid;
      e2_valid <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_prod[i] <= 64'(u4_refl[i]) * 64'(u4_view[i]);
        e1_diff[i] <= u4_diff[i];
        e2_diff[i] <= e1_diff[i];
      end
      e1_cpos <= u4_cpos;
      // A specular term only appears when both cosines are positive.
      e2_p <= (e1_cpos && (cos_a > 35'sd0)) ? spsh_pkg::UNIT_ONE : '0;
      e2_c <= clamp_cos(cos_a);
    end
  end

  logic sp_valid;
  spsh_pkg::spec_t sp_p;
  spsh_pkg::diff_t sp_diff [3];

  spsh_spec #(.POWER(SPECULAR_POWER)) u_spec (
    .clk(clk), .rst(rst), .en(adv), .in_valid(e2_valid),
    .p_in(e2_p), .c_in(e2_c), .diff_in(e2_diff),
    .out_valid(sp_valid), .p_out(sp_p), .diff_out(sp_diff)
  );

  // Ambient + diffuse + specular, saturated, into the output register.
  logic [17:0] acc [3];
  logic [15:0] chan_out [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 18'(spsh_pkg::AMBIENT) + 18'(sp_diff[i]) + 18'(sp_p >> 22);
      chan_out[i] = (acc[i] > 18'(spsh_pkg::OUT_MAX)) ? spsh_pkg::OUT_MAX : acc[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.red <= chan_out[0];
      out_data.green <= chan_out[1];
      out_data.blue <= chan_out[2];
    end
  end

endmodule

[src/spsh_unitize.sv]
// Pipelined vector normaliser: range shift, sum of squares, a square root
// of one result bit per stage, then three dividers of one quotient bit per stage.
module spsh_unitize (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  spsh_pkg::wide_t      vec_in [3],
  input  spsh_pkg::side_t      side_in,
  output logic                 out_valid,
  output spsh_pkg::unit_t      vec_out [3],
  output spsh_pkg::side_t      side_out
);

  localparam int VW = spsh_pkg::VEC_W;
  localparam int MW = spsh_pkg::MAG_W;
  localparam int SQ = spsh_pkg::SQRT_STEPS;
  localparam int DV = spsh_pkg::DIV_STEPS;
  localparam int HI_W = VW - MW;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [DV-1:0] q;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t cur, input int unsigned k);
    logic [63:0] b;
    logic [63:0] t;
    sq_t nxt;
    b = 64'd1 << (62 - 2 * k);
    t = cur.r + b;
    if (cur.x >= t) begin
      nxt.x = cur.x - t;
      nxt.r = (cur.r >> 1) + b;
    end else begin
      nxt.x = cur.x;
      nxt.r = cur.r >> 1;
    end
    return nxt;
  endfunction

  function automatic dv_t div_step(input dv_t cur, input logic [31:0] len, input logic bin);
    logic [32:0] r2;
    dv_t nxt;
    r2 = {cur.rem, bin};
    if (r2 >= {1'b0, len}) begin
      nxt.rem = 32'(r2 - {1'b0, len});
      nxt.q = {cur.q[DV-2:0], 1'b1};
    end else begin
      nxt.rem = r2[31:0];
      nxt.q = {cur.q[DV-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // Stage A: magnitudes and signs.
  logic a_valid;
  logic [VW-1:0] a_mag [3];
  logic a_neg [3];
  spsh_pkg::side_t a_side;

  // Stage B: magnitudes shifted below 2^31.
  logic b_valid;
  logic [MW-1:0] b_mag [3];
  logic b_neg [3];
  spsh_pkg::side_t b_side;

  // Stage C: squares.
  logic c_valid;
  logic [2*MW-1:0] c_sq [3];
  logic [MW-1:0] c_mag [3];
  logic c_neg [3];
  spsh_pkg::side_t c_side;

  // Square root pipeline; entry 0 holds the sum of squares.
  logic s_valid [SQ+1];
  sq_t s_st [SQ+1];
  logic [MW-1:0] s_mag [SQ+1][3];
  logic s_neg [SQ+1][3];
  logic s_zero [SQ+1];
  spsh_pkg::side_t s_side [SQ+1];

  // Divider pipeline.
  logic v_valid [DV];
  dv_t v_st [DV][3];
  logic [31:0] v_len [DV];
  logic v_neg [DV][3];
  logic v_zero [DV];
  spsh_pkg::side_t v_side [DV];

  logic [VW-1:0] mx;
  logic [HI_W-1:0] hi;
  logic [2:0] sh;
  logic [31:0] len_s;

  always_comb begin
    mx = a_mag[0];
    if (a_mag[1] > mx) begin
      mx = a_mag[1];
    end
    if (a_mag[2] > mx) begin
      mx = a_mag[2];
    end
    hi = mx[VW-1:MW];
    sh = '0;
    for (int j = 0; j < HI_W; j++) begin
      if (hi[j]) begin
        sh = 3'(j + 1);
      end
    end
  end

  assign len_s = s_st[SQ].r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      for (int k = 0; k <= SQ; k++) begin
        s_valid[k] <= 1'b0;
      end
      for (int k = 0; k < DV; k++) begin
        v_valid[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      s_valid[0] <= c_valid;
      for (int k = 0; k < SQ; k++) begin
        s_valid[k+1] <= s_valid[k];
      end
      v_valid[0] <= s_valid[SQ];
      for (int k = 0; k < DV - 1; k++) begin
        v_valid[k+1] <= v_valid[k];
      end
      out_valid <= v_valid[DV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_mag[i] <= vec_in[i][VW-1] ? VW'(-vec_in[i]) : VW'(vec_in[i]);
        a_neg[i] <= vec_in[i][VW-1];
        b_mag[i] <= MW'(a_mag[i] >> sh);
        b_neg[i] <= a_neg[i];
        c_sq[i] <= (2*MW)'(b_mag[i]) * (2*MW)'(b_mag[i]);
        c_mag[i] <= b_mag[i];
        c_neg[i] <= b_neg[i];
      end
      a_side <= side_in;
      b_side <= a_side;
      c_side <= b_side;
    end
  end

  // Sum of squares, then one root bit per stage.
  always_ff @(posedge clk) begin
    if (en) begin
      s_st[0].x <= 64'(c_sq[0]) + 64'(c_sq[1]) + 64'(c_sq[2]);
      s_st[0].r <= '0;
      s_zero[0] <= (c_sq[0] == '0) && (c_sq[1] == '0) && (c_sq[2] == '0);
      s_side[0] <= c_side;
      for (int i = 0; i < 3; i++) begin
        s_mag[0][i] <= c_mag[i];
        s_neg[0][i] <= c_neg[i];
      end
      for (int k = 0; k < SQ; k++) begin
        s_st[k+1] <= sqrt_step(s_st[k], k);
        s_zero[k+1] <= s_zero[k];
        s_side[k+1] <= s_side[k];
        for (int i = 0; i < 3; i++) begin
          s_mag[k+1][i] <= s_mag[k][i];
          s_neg[k+1][i] <= s_neg[k][i];
        end
      end
    end
  end

  // Quotient (m << 30) / len, one bit per stage; m never exceeds len.
  always_ff @(posedge clk) begin
    if (en) begin
      v_len[0] <= len_s;
      v_zero[0] <= s_zero[SQ];
      v_side[0] <= s_side[SQ];
      for (int i = 0; i < 3; i++) begin
        v_st[0][i] <= div_step('{rem: 32'(s_mag[SQ][i] >> 1), q: '0}, len_s,
                               s_mag[SQ][i][0]);
        v_neg[0][i] <= s_neg[SQ][i];
      end
      for (int k = 0; k < DV - 1; k++) begin
        v_len[k+1] <= v_len[k];
        v_zero[k+1] <= v_zero[k];
        v_side[k+1] <= v_side[k];
        for (int i = 0; i < 3; i++) begin
          v_st[k+1][i] <= div_step(v_st[k][i], v_len[k], 1'b0);
          v_neg[k+1][i] <= v_neg[k][i];
        end
      end
      for (int i = 0; i < 3; i++) begin
        if (v_zero[DV-1]) begin
          vec_out[i] <= '0;
        end else if (v_neg[DV-1][i]) begin
          vec_out[i] <= -$signed({1'b0, v_st[DV-1][i].q});
        end else begin
          vec_out[i] <= $signed({1'b0, v_st[DV-1][i].q});
        end
      end
      side_out <= v_side[DV-1];
    end
  end

endmodule

[src/spsh_spec.sv]
// Specular power chain: one truncating Q1.30 multiply per stage.
module spsh_spec #(
  parameter int POWER = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  spsh_pkg::spec_t      p_in,
  input  spsh_pkg::spec_t      c_in,
  input  spsh_pkg::diff_t      diff_in [3],
  output logic                 out_valid,
  output spsh_pkg::spec_t      p_out,
  output spsh_pkg::diff_t      diff_out [3]
);

  localparam int PW = spsh_pkg::SPEC_W;
  localparam int UB = spsh_pkg::UNIT_BITS;

  function automatic spsh_pkg::spec_t pmul(input spsh_pkg::spec_t a,
                                           input spsh_pkg::spec_t b);
    logic [2*PW-1:0] pr;
    pr = (2*PW)'(a) * (2*PW)'(b);
    return pr[UB+PW-1:UB];
  endfunction

  logic val [POWER];
  spsh_pkg::spec_t p [POWER];
  spsh_pkg::spec_t c [POWER];
  spsh_pkg::diff_t d [POWER][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < POWER; k++) begin
        val[k] <= 1'b0;
      end
    end else if (en) begin
      val[0] <= in_valid;
      for (int k = 0; k < POWER - 1; k++) begin
        val[k+1] <= val[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= pmul(p_in, c_in);
      c[0] <= c_in;
      for (int i = 0; i < 3; i++) begin
        d[0][i] <= diff_in[i];
      end
      for (int k = 0; k < POWER - 1; k++) begin
        p[k+1] <= pmul(p[k], c[k]);
        c[k+1] <= c[k];
        for (int i = 0; i < 3; i++) begin
          d[k+1][i] <= d[k][i];
        end
      end
    end
  end

  assign out_valid = val[POWER-1];
  assign p_out = p[POWER-1];
  assign diff_out = d[POWER-1];

endmodule

[src/spsh_checker.sv]
// Port-level checks for the shading unit.
module spsh_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input spsh_pkg::out_item_t out_data
);

`include "sphere_phong_shading_unit_macros.svh"

  `SPSH_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `SPSH_CHECK(a_in_stall, in_stall == (out_valid && out_stall), "input stall does not follow held result")
  `SPSH_CHECK(a_ambient, out_valid |-> (out_data.red >= 16'd26 && out_data.green >= 16'd26 && out_data.blue >= 16'd26), "result below ambient level")
  `SPSH_CHECK_ALWAYS(a_reset, $past(rst) |-> !out_valid, "result valid straight after reset")

endmodule

bind sphere_phong_shading_unit spsh_checker u_spsh_checker (.*);
